@@ rtl/ps2_mouse_packet_framer_top_defines.svh @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet framer assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_FRAMER_TOP_DEFINES_SVH
`define PS2_MOUSE_PACKET_FRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define PMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_pkg
// Types and constants shared by the PS/2 mouse packet framer.
// ----------------------------------------------------------------------------
package pmf_pkg;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_ID   = 2'd2
  } mode_t;

  localparam logic [7:0] SYNC_MASK    = 8'h08;
  localparam logic [7:0] CMD_RATE     = 8'hF3;
  localparam logic [7:0] CMD_RES      = 8'hE8;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] ID_WHEEL     = 8'h03;
  localparam logic [7:0] RATE_FIRST   = 8'd200;
  localparam logic [7:0] RATE_SECOND  = 8'd100;
  localparam logic [7:0] RATE_THIRD   = 8'd80;

  localparam logic [1:0] SLOT_LAST_STD   = 2'd2;
  localparam logic [1:0] SLOT_LAST_WHEEL = 2'd3;

  // completed packet handed from the framer to the output serializer
  typedef struct packed {
    logic            load;
    logic            wheel;
    logic [3:0][7:0] bytes;
  } pkt_t;

endpackage

@@ rtl/ps2_mouse_packet_framer_top.sv @@
`timescale 1ns / 1ps
// Timing: a transferred item is held in the input register and framed from there;
//   a packet it completes is loaded into the serializer buffer, and its first byte shows on out_*.
// Throughput: one item per cycle unless stalled; a packet drains at one byte per
//   cycle while out_tready is high (3 or 4 bytes). The serializer buffer stalls
//   input only when a packet completes while the previous packet is still draining.
// Reset: synchronous, active low; clears control state, packet bytes stay undefined.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_framer_top
// Frames PS/2 mouse data bytes into 3- or 4-byte packets and tracks the
// wheel-mode enable handshake from host commands and device id replies.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_framer_top_defines.svh"

module ps2_mouse_packet_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_value, [8] acked, [15:9] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] packet_byte, [9:8] byte_slot, [15:10] zero
  output logic        out_tlast,  // last_of_packet
  output logic        out_tuser   // [0] wheel_active
);
  import pmf_pkg::*;

  // input register
  logic       in_valid_r;
  mode_t      in_mode_r;
  logic [7:0] in_byte_r;
  logic       in_acked_r;

  logic consume, emit_ready;
  pkt_t pkt;

  // take a new item when none is held or the held one moves on this cycle
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r  <= mode_t'(in_tuser);
      in_byte_r  <= in_tdata[7:0];
      in_acked_r <= in_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  // framing and handshake tracking; hold the item when its packet cannot be handed off
  pmf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item_mode  (in_mode_r),
    .item_byte  (in_byte_r),
    .item_acked (in_acked_r),
    .emit_ready (emit_ready),
    .consume    (consume),
    .pkt        (pkt)
  );

  // result register: one packet buffer drained a byte per transfer
  pmf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pkt        (pkt),
    .ready      (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // last byte sits in the slot that matches the packet length
  `PMF_ASSERT_NOW(a_last_slot, out_tvalid && out_tlast, out_tdata[9:8] == (out_tuser ? SLOT_LAST_WHEEL : SLOT_LAST_STD), "last byte in wrong slot")
  // a non-final transfer is followed by the next slot of the same packet
  `PMF_ASSERT_NEXT(a_slot_step, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tdata[9:8] == $past(out_tdata[9:8]) + 2'd1, "slot did not advance")
  // a held item stays held until the framer takes it
  `PMF_ASSERT_NEXT(a_hold_item, in_valid_r && !consume, in_valid_r && $stable(in_byte_r), "held item lost")
  // a packet is only handed off to a free serializer
  `PMF_ASSERT_NOW(a_load_free, pkt.load, emit_ready, "packet loaded over busy buffer")

endmodule

@@ rtl/pmf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_core
// Packet framing and wheel-mode handshake tracking for one registered item.
// ----------------------------------------------------------------------------
module pmf_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  pmf_pkg::mode_t item_mode,
  input  logic [7:0]     item_byte,
  input  logic           item_acked,
  input  logic           emit_ready,
  output logic           consume,
  output pmf_pkg::pkt_t  pkt
);
  import pmf_pkg::*;

  logic [7:0] store_r [4];
  logic [1:0] pos_r, pos_nxt;
  logic       wheel_r, wheel_nxt;
  logic [7:0] hist_r [3];
  logic [7:0] hist_nxt [3];
  logic       expect_r, expect_nxt;
  logic [7:0] pend_r, pend_nxt;

  logic is_data, completes, store_we;

  assign is_data   = item_valid && (item_mode == MODE_DATA);
  // position 0 never completes, so the sync drop cannot matter here
  assign completes = (pos_r == SLOT_LAST_WHEEL) || (!wheel_r && pos_r == SLOT_LAST_STD);
  assign consume   = item_valid && !(is_data && completes && !emit_ready);
  assign store_we  = consume && is_data && !(pos_r == 2'd0 && (item_byte & SYNC_MASK) == 8'd0);

  always_comb begin
    pos_nxt     = pos_r;
    wheel_nxt   = wheel_r;
    hist_nxt    = hist_r;
    expect_nxt  = expect_r;
    pend_nxt    = pend_r;
    pkt.load    = 1'b0;
    pkt.wheel   = wheel_r;
    for (int i = 0; i < 4; i++) begin
      pkt.bytes[i] = (pos_r == 2'(i)) ? item_byte : store_r[i];
    end
    if (consume) begin
      unique case (item_mode)
        MODE_DATA: begin
          if (store_we) begin
            if (completes) begin
              pos_nxt  = 2'd0;
              pkt.load = 1'b1;
            end else begin
              pos_nxt  = pos_r + 2'd1;
            end
          end
        end
        MODE_CMD: begin
          if (expect_r) begin
            if (item_acked && pend_r == CMD_RATE) begin
              hist_nxt[0] = hist_r[1];
              hist_nxt[1] = hist_r[2];
              hist_nxt[2] = item_byte;
              if (hist_r[1] == RATE_FIRST && hist_r[2] == RATE_SECOND &&
                  item_byte == RATE_THIRD) begin
                wheel_nxt = 1'b1;
                pos_nxt   = 2'd0;
              end
            end
            expect_nxt = 1'b0;
            pend_nxt   = 8'd0;
          end else if (item_byte == CMD_RATE || item_byte == CMD_RES) begin
            expect_nxt = 1'b1;
            pend_nxt   = item_byte;
          end else if (item_byte == CMD_DEFAULTS) begin
            hist_nxt   = '{default: 8'd0};
            wheel_nxt  = 1'b0;
            pos_nxt    = 2'd0;
            expect_nxt = 1'b0;
            pend_nxt   = 8'd0;
          end else if (item_byte == CMD_RESET) begin
            hist_nxt   = '{default: 8'd0};
            expect_nxt = 1'b0;
            pend_nxt   = 8'd0;
          end
        end
        MODE_ID: begin
          wheel_nxt = (item_byte == ID_WHEEL);
          pos_nxt   = 2'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_r] <= item_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 2'd0;
      wheel_r  <= 1'b0;
      hist_r   <= '{default: 8'd0};
      expect_r <= 1'b0;
      pend_r   <= 8'd0;
    end else begin
      pos_r    <= pos_nxt;
      wheel_r  <= wheel_nxt;
      hist_r   <= hist_nxt;
      expect_r <= expect_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

@@ rtl/pmf_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_emit
// Holds one completed packet and sends it out one byte per transfer.
// ----------------------------------------------------------------------------
module pmf_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  pmf_pkg::pkt_t pkt,
  output logic          ready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);
  import pmf_pkg::*;

  logic [7:0] buf_r [4];
  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wheel_r;
  logic       last, xfer;

  assign last  = (cnt_r == (wheel_r ? SLOT_LAST_WHEEL : SLOT_LAST_STD));
  assign xfer  = busy_r && out_tready;
  assign ready = !busy_r || (out_tready && last);

  assign out_tvalid = busy_r;
  assign out_tdata  = {6'd0, cnt_r, buf_r[cnt_r]};
  assign out_tlast  = last;
  assign out_tuser  = wheel_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (pkt.load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (xfer) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.load) begin
      wheel_r <= pkt.wheel;
      for (int i = 0; i < 4; i++) begin
        buf_r[i] <= pkt.bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ verif/ps2_mouse_packet_framer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_framer_checker
// Watches both streams of the framer, predicts every packet byte it must emit
// and compares each output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_framer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int          error_count,
  output int          bytes_awaited
);
  import pmf_pkg::*;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic [1:0] byte_slot;
    logic       last_of_packet;
    logic       wheel_active;
  } packet_byte_t;

  packet_byte_t predicted_bytes[$];

  logic [7:0] stored_bytes[4];
  logic [1:0] frame_pos;
  logic       four_byte;
  logic [7:0] rate_hist[3];
  logic       param_armed;
  logic [7:0] armed_cmd;

  initial begin
    error_count   = 0;
    bytes_awaited = 0;
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic select_wheel(input logic wheel);
    four_byte = wheel;
    frame_pos = 2'd0;
  endtask

  task automatic clear_rates();
    rate_hist[0] = 8'd0;
    rate_hist[1] = 8'd0;
    rate_hist[2] = 8'd0;
  endtask

  task automatic frame_input(input logic [1:0] mode, input logic [7:0] value,
                             input logic ack);
    int           len;
    packet_byte_t b;
    len = four_byte ? 4 : 3;
    case (mode)
      MODE_DATA: begin
        if (frame_pos != 2'd0 || (value & SYNC_MASK) != 8'd0) begin
          stored_bytes[frame_pos] = value;
          frame_pos = frame_pos + 2'd1;
          if (frame_pos == 2'd0 || frame_pos >= len) begin
            frame_pos = 2'd0;
            for (int i = 0; i < len; i++) begin
              b.packet_byte    = stored_bytes[i];
              b.byte_slot      = i[1:0];
              b.last_of_packet = (i == len - 1);
              b.wheel_active   = four_byte;
              predicted_bytes.push_back(b);
            end
          end
        end
      end
      MODE_CMD: begin
        if (param_armed) begin
          // only an acknowledged sample rate moves the history
          if (ack && armed_cmd == CMD_RATE) begin
            rate_hist[0] = rate_hist[1];
            rate_hist[1] = rate_hist[2];
            rate_hist[2] = value;
            if (rate_hist[0] == RATE_FIRST && rate_hist[1] == RATE_SECOND &&
                rate_hist[2] == RATE_THIRD)
              select_wheel(1'b1);
          end
          param_armed = 1'b0;
          armed_cmd   = 8'd0;
        end else if (value == CMD_RATE || value == CMD_RES) begin
          param_armed = 1'b1;
          armed_cmd   = value;
        end else if (value == CMD_DEFAULTS) begin
          clear_rates();
          select_wheel(1'b0);
          param_armed = 1'b0;
          armed_cmd   = 8'd0;
        end else if (value == CMD_RESET) begin
          clear_rates();
          param_armed = 1'b0;
          armed_cmd   = 8'd0;
        end
      end
      MODE_ID: select_wheel(value == ID_WHEEL);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    packet_byte_t want;
    if (!rst_n) begin
      frame_pos   = 2'd0;
      four_byte   = 1'b0;
      param_armed = 1'b0;
      armed_cmd   = 8'd0;
      clear_rates();
      predicted_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_bytes.size() == 0) begin
          $error("unexpected packet byte 0x%0h", out_tdata[7:0]);
          error_count++;
        end else begin
          want = predicted_bytes.pop_front();
          check_field("packet_byte", int'(want.packet_byte), int'(out_tdata[7:0]));
          check_field("byte_slot", int'(want.byte_slot), int'(out_tdata[9:8]));
          check_field("last_of_packet", int'(want.last_of_packet), int'(out_tlast));
          check_field("wheel_active", int'(want.wheel_active), int'(out_tuser));
        end
      end
      if (in_tvalid && in_tready)
        frame_input(in_tuser, in_tdata[7:0], in_tdata[8]);
    end
    bytes_awaited = predicted_bytes.size();
  end

endmodule

@@ verif/ps2_mouse_packet_framer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_framer_top_test
// Drives data bytes, host commands and device ids into the framer, first a
// directed walk through dropping, framing and the wheel handshake, then
// random traffic under several idle and stall patterns; a side checker
// predicts and compares every emitted packet byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_framer_top_test;
  import pmf_pkg::*;

  // the tuser encoding the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 420;
  localparam int PHASES         = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] byte_value, [8] acked, [15:9] zero
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] packet_byte, [9:8] byte_slot, [15:10] zero
  logic        out_tlast;
  logic        out_tuser;  // [0] wheel_active

  int error_count;
  int bytes_awaited;
  int sender_idle_pct;
  int receiver_stall_pct;
  int items_sent;
  int quiet_cycles;
  bit wheel_on;  // what the stimulus believes the packet length is

  ps2_mouse_packet_framer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  ps2_mouse_packet_framer_checker packet_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .bytes_awaited (bytes_awaited)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver: redraw backpressure every falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[ps2_mouse_packet_framer_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item at a falling edge and hold it until the transfer; return at
  // the falling edge after the transfer.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] value,
                           input logic ack);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, ack, value};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // One movement packet; now and then of random length or without its sync bit.
  task automatic send_packet();
    int         len;
    logic [7:0] head;
    bit         broken;
    broken = ($urandom_range(9) == 0);
    len    = broken ? int'($urandom_range(1, 4)) : (wheel_on ? 4 : 3);
    head   = 8'($urandom_range(255));
    if (!broken || $urandom_range(1)) head = head | SYNC_MASK;
    send_item(MODE_DATA, head, 1'($urandom_range(1)));
    for (int i = 1; i < len; i++)
      send_item(MODE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Sample-rate knock sequence 200, 100, 80; occasionally spoiled.
  task automatic wheel_handshake();
    logic [7:0] rates[3];
    logic [7:0] rate;
    logic       ack;
    bit         clean;
    rates = '{RATE_FIRST, RATE_SECOND, RATE_THIRD};
    clean = 1'b1;
    for (int i = 0; i < 3; i++) begin
      rate = rates[i];
      ack  = 1'b1;
      case ($urandom_range(15))
        0: rate = 8'($urandom_range(255));
        1: ack = 1'b0;
        default: ;
      endcase
      if (rate != rates[i] || !ack) clean = 1'b0;
      send_item(MODE_CMD, CMD_RATE, 1'($urandom_range(1)));
      send_item(MODE_CMD, rate, ack);
    end
    if (clean) wheel_on = 1'b1;
  endtask

  task automatic send_command();
    logic [7:0] value;
    case ($urandom_range(3))
      0: begin
        send_item(MODE_CMD, CMD_DEFAULTS, 1'($urandom_range(1)));
        wheel_on = 1'b0;
      end
      1: send_item(MODE_CMD, CMD_RESET, 1'($urandom_range(1)));
      2: begin
        send_item(MODE_CMD, CMD_RES, 1'($urandom_range(1)));
        send_item(MODE_CMD, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      default: begin
        value = 8'($urandom_range(255));
        send_item(MODE_CMD, value, 1'($urandom_range(1)));
        if (value == CMD_DEFAULTS) wheel_on = 1'b0;
      end
    endcase
  endtask

  task automatic send_noise();
    logic [1:0] mode;
    logic [7:0] value;
    mode  = 2'($urandom_range(3));
    value = 8'($urandom_range(255));
    send_item(mode, value, 1'($urandom_range(1)));
    if (mode == MODE_ID) wheel_on = (value == ID_WHEEL);
  endtask

  // Random device id report.
  task automatic send_noise_id();
    logic [7:0] value;
    value = 8'($urandom_range(255));
    send_item(MODE_ID, value, 1'($urandom_range(1)));
    wheel_on = (value == ID_WHEEL);
  endtask

  initial begin
    int pick;
    int phase_target;
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = 16'd0;
    in_tuser           = MODE_DATA;
    out_tready         = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    items_sent         = 0;
    quiet_cycles       = 0;
    wheel_on           = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk, no idling.
    send_item(MODE_DATA, 8'h00, 1'b0);        // no sync bit at position 0: drop
    send_item(MODE_DATA, 8'h08, 1'b1);
    send_item(MODE_DATA, 8'h00, 1'b0);
    send_item(MODE_DATA, 8'hFF, 1'b1);        // standard packet complete
    send_item(MODE_DATA, 8'hFF, 1'b0);
    send_item(MODE_DATA, 8'h80, 1'b0);
    send_item(MODE_ID, 8'h00, 1'b1);          // id restarts framing mid-packet
    send_item(MODE_CMD, CMD_RATE, 1'b1);
    send_item(MODE_CMD, RATE_FIRST, 1'b1);
    send_item(MODE_CMD, CMD_RATE, 1'b0);
    send_item(MODE_CMD, RATE_SECOND, 1'b1);
    send_item(MODE_CMD, CMD_RATE, 1'b1);
    send_item(MODE_CMD, RATE_THIRD, 1'b1);    // knock complete: wheel mode
    send_item(MODE_DATA, 8'h18, 1'b0);
    send_item(MODE_DATA, 8'h01, 1'b0);
    send_item(MODE_DATA, 8'h02, 1'b1);
    send_item(MODE_DATA, 8'h7F, 1'b0);        // four-byte packet complete
    send_item(MODE_CMD, CMD_DEFAULTS, 1'b1);  // back to standard
    send_item(MODE_CMD, CMD_RES, 1'b1);
    send_item(MODE_CMD, ID_WHEEL, 1'b1);      // resolution parameter, not an id
    send_item(MODE_CMD, CMD_RESET, 1'b0);
    send_item(MODE_CMD, CMD_RATE, 1'b1);
    send_item(MODE_CMD, RATE_FIRST, 1'b0);    // unacknowledged rate: ignored
    send_item(MODE_ID, ID_WHEEL, 1'b0);       // wheel by id
    send_item(MODE_UNUSED, 8'hFF, 1'b1);      // undefined mode: ignored
    send_item(MODE_ID, 8'h07, 1'b0);          // any other id: standard

    // Random traffic, one idling pattern per phase.
    items_sent = 0;
    wheel_on   = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
      endcase
      phase_target = (ph + 1) * RANDOM_ITEMS / PHASES;
      while (items_sent < phase_target) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_packet();
        end else if (pick < 70) begin
          wheel_handshake();
        end else if (pick < 80) begin
          if ($urandom_range(1)) begin
            send_item(MODE_ID, ID_WHEEL, 1'($urandom_range(1)));
            wheel_on = 1'b1;
          end else begin
            send_noise_id();
          end
        end else if (pick < 90) begin
          send_command();
        end else begin
          send_noise();
        end
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted byte, then watch a little longer.
    while (bytes_awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("[ps2_mouse_packet_framer_top] OK");
    end else begin
      $display("[ps2_mouse_packet_framer_top] ERROR");
    end
    $finish;
  end

endmodule
